>>> sv/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and codes of the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int unsigned SLOTS_DEF = 8;

	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_LOAD    = 3'd1;
	localparam logic [2:0] REQ_ENABLE  = 3'd2;
	localparam logic [2:0] REQ_DISABLE = 3'd3;
	localparam logic [2:0] REQ_SUSPEND = 3'd4;

	localparam logic KIND_SLOT = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	// one slot entry of the task memory
	typedef struct packed {
		logic [15:0]        id;
		logic [31:0]        period;
		logic [31:0]        prev_time;
		logic signed [16:0] runs_left;
	} slot_entry_t;

endpackage

>>> sv/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Fixed-slot periodic task scheduler with a tick walk over a slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request beat: tick, load or
//   clear a slot, enable all, disable all, or suspend by id.
//   Output channel (out_valid/out_ready) gives report beats; the final beat
//   of each request has last set.
//   Load, enable, disable and unknown requests go through the done state and
//   produce one acknowledge beat.
//   A tick walks the slot memory one slot per cycle while the receiver does
//   not stall, and stops after the highest occupied slot, with one report
//   beat per occupied slot (one acknowledge beat if none is occupied).
//   Suspend by id walks the memory the same way to compare ids, then
//   acknowledges.
//   The single memory read port sets the one-slot-per-cycle pace.
//   Slot id, period, time and run count sit in a synchronous memory read
//   ahead of use; flag bits (used, enabled, retire, suspend) are flops
//   that reset clears. Memory contents are undefined until a load.
//   One item is processed at a time; a stalled receiver holds the output
//   register; a tick walk pauses on an occupied slot until the beat is taken.
//   In_ready is high once idle with the output register empty or being taken.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher #(
	parameter int unsigned SLOTS = ptd_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [31:0]        now,
	input  logic [2:0]         slot,
	input  logic [15:0]        task_id,
	input  logic [31:0]        period,
	input  logic signed [16:0] runs_left,
	input  logic               retire_on_last,
	input  logic               start_enabled,
	input  logic               occupy,
	input  logic [31:0]        start_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               report_kind,
	output logic [2:0]         slot_index,
	output logic [15:0]        slot_task_id,
	output logic               fired,
	output logic               retired,
	output logic signed [31:0] overrun,
	output logic               last
);
	import ptd_pkg::*;

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// state flops
	logic [SLOTS-1:0] used_q, en_q, ret_q, susp_q;
	slot_entry_t      mem [SLOTS];
	slot_entry_t      rd_s1;
	logic [1:0]       state_q;
	logic [AW:0]      rd_idx_q;     // read issue pointer (next slot to read)
	logic             rd_vld_s1;    // rd_s1 holds slot walk_idx_s1
	logic [AW-1:0]    walk_idx_s1;
	logic [31:0]      now_q;
	logic             any_q;        // a report was already produced
	logic             sus_q;        // walk marks id matches instead of reporting
	logic [15:0]      sid_q;        // id to mark during a suspend walk

	// output register
	logic               ov_q;
	logic               kind_q;
	logic [2:0]         idx_q;
	logic [15:0]        id_q;
	logic               fired_q, retired_q, last_q;
	logic signed [31:0] ovr_q;

	// --------------------------------------------------------------------
	// per-slot combinational update of the slot being walked
	logic [AW-1:0] wi;
	logic          w_used, w_en, w_ret;
	logic [31:0]   target, new_prev;
	logic          c_fire, c_retire, c_dec;
	logic signed [16:0] new_runs;
	logic [31:0]   c_ovr;

	always_comb begin
		wi       = walk_idx_s1;
		w_used   = used_q[wi];
		w_en     = en_q[wi];
		w_ret    = ret_q[wi];
		target   = rd_s1.prev_time + rd_s1.period;
		new_prev = rd_s1.prev_time;
		c_fire   = 1'b0;
		c_retire = 1'b0;
		c_ovr    = 32'd0;
		if (w_en) begin
			if (rd_s1.runs_left == 17'sd0) begin
				c_retire = w_ret;
			end else if (rd_s1.period != 32'd0) begin
				if (target <= now_q) begin
					c_fire   = 1'b1;
					new_prev = target;
					c_ovr    = target + rd_s1.period - now_q;
				end
			end else begin
				c_fire = 1'b1;
			end
		end
		c_dec    = c_fire && (rd_s1.runs_left > 17'sd0);
		new_runs = c_dec ? rd_s1.runs_left - 17'sd1 : rd_s1.runs_left;
	end

	// walk may advance a slot when the output register can take a beat, or at once for an unused slot or a suspend walk
	logic out_free;
	logic step;
	logic walk_end;
	logic ov_set;
	assign out_free = !ov_q || out_ready;
	assign step     = (state_q == ST_WALK) && rd_vld_s1 &&
		(sus_q || !w_used || out_free);
	// no occupied slot left at or after the read pointer
	assign walk_end = (rd_idx_q == (AW+1)'(SLOTS)) || !(|(used_q >> rd_idx_q));
	assign ov_set   = (step && w_used && !sus_q) || (state_q == ST_DONE && out_free);

	assign in_ready = (state_q == ST_IDLE) && out_free;

	logic take;
	assign take = in_valid && in_ready;

	// --------------------------------------------------------------------
	// memory: one write port, one registered read port
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	slot_entry_t   mem_wd;
	logic          ld_ok;
	logic [AW-1:0] ld_idx;

	assign ld_ok  = ({{(32-3){1'b0}}, slot} < SLOTS);
	assign ld_idx = AW'(slot);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wi;
		mem_wd = rd_s1;
		if (take && req_type == REQ_LOAD && ld_ok && occupy) begin
			mem_we = 1'b1;
			mem_wa = ld_idx;
			mem_wd = '{id: task_id, period: period, prev_time: start_time,
				runs_left: runs_left};
		end else if (step && w_used && c_fire && !sus_q) begin
			mem_we           = 1'b1;
			mem_wd.prev_time = new_prev;
			mem_wd.runs_left = new_runs;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == ST_WALK && (!rd_vld_s1 || step)) begin
			rd_s1 <= mem[rd_idx_q[AW-1:0]];
		end
	end

	// --------------------------------------------------------------------
	// control and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			en_q      <= '0;
			ret_q     <= '0;
			susp_q    <= '0;
			state_q   <= ST_IDLE;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			any_q     <= 1'b0;
			sus_q     <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (req_type)
							REQ_TICK: begin
								en_q      <= en_q & ~(susp_q & used_q);
								susp_q    <= '0;
								now_q     <= now;
								rd_idx_q  <= '0;
								rd_vld_s1 <= 1'b0;
								any_q     <= 1'b0;
								sus_q     <= 1'b0;
								state_q   <= ST_WALK;
							end
							REQ_LOAD: begin
								if (ld_ok) begin
									susp_q[ld_idx] <= 1'b0;
									used_q[ld_idx] <= occupy;
									if (occupy) begin
										ret_q[ld_idx] <= retire_on_last;
										en_q[ld_idx]  <= start_enabled;
									end else begin
										en_q[ld_idx] <= 1'b0;
									end
								end
								state_q <= ST_DONE;
							end
							REQ_ENABLE: begin
								en_q    <= en_q | used_q;
								state_q <= ST_DONE;
							end
							REQ_DISABLE: begin
								en_q    <= en_q & ~used_q;
								state_q <= ST_DONE;
							end
							REQ_SUSPEND: begin
								// walk the ids; mark matches, report nothing
								sid_q     <= task_id;
								rd_idx_q  <= '0;
								rd_vld_s1 <= 1'b0;
								sus_q     <= 1'b1;
								state_q   <= ST_WALK;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (!rd_vld_s1) begin
						rd_vld_s1   <= 1'b1;
						walk_idx_s1 <= rd_idx_q[AW-1:0];
						rd_idx_q    <= rd_idx_q + 1'b1;
					end else if (step) begin
						if (w_used && sus_q) begin
							if (rd_s1.id == sid_q) begin
								susp_q[wi] <= 1'b1;
							end
						end else if (w_used) begin
							if (c_retire) begin
								en_q[wi] <= 1'b0;
							end
							kind_q    <= KIND_SLOT;
							idx_q     <= 3'(wi);
							id_q      <= rd_s1.id;
							fired_q   <= c_fire;
							retired_q <= c_retire;
							ovr_q     <= c_ovr;
							last_q    <= walk_end;
							any_q     <= 1'b1;
						end
						if (walk_end) begin
							rd_vld_s1 <= 1'b0;
							if (sus_q) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= (w_used || any_q) ? ST_IDLE : ST_DONE;
							end
						end else begin
							walk_idx_s1 <= rd_idx_q[AW-1:0];
							rd_idx_q    <= rd_idx_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						kind_q    <= KIND_ACK;
						idx_q     <= '0;
						id_q      <= '0;
						fired_q   <= 1'b0;
						retired_q <= 1'b0;
						ovr_q     <= '0;
						last_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// load a new beat, or drop the one the receiver takes
			if (ov_set) begin
				ov_q <= 1'b1;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid    = ov_q;
	assign report_kind  = kind_q;
	assign slot_index   = idx_q;
	assign slot_task_id = id_q;
	assign fired        = fired_q;
	assign retired      = retired_q;
	assign overrun      = ovr_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && kind_q == KIND_ACK) |-> last_q)
		else $error("acknowledge without last");
	a_fire_xor_retire: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> !(fired_q && retired_q))
		else $error("fired and retired together");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> (ov_q && $stable(idx_q) && $stable(last_q)))
		else $error("output beat changed under stall");
`endif

endmodule
